// File: hw/rtl/dmlpc_pkg.sv
`default_nettype none

package dmlpc_pkg;

	// Interface mode codes
	localparam logic [2:0] MODE_RUNNING   = 3'd0;
	localparam logic [2:0] MODE_LENGTH    = 3'd1;
	localparam logic [2:0] MODE_JACK_ZERO = 3'd2;
	localparam logic [2:0] MODE_JACK_DOWN = 3'd3;
	localparam logic [2:0] MODE_JACK_UP   = 3'd4;

	// Setting stage codes
	localparam logic [1:0] STAGE_DONE     = 2'd0;
	localparam logic [1:0] STAGE_JACK_LIM = 2'd1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_POS     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS = 2'd2;
	localparam int CFG_DATA_W = 16;

	localparam logic [15:0] SETTLE_TICKS_RESET = 16'd20;

	typedef struct packed {
		logic               motor_id;
		logic [2:0]         interface_mode;
		logic [1:0]         setting_stage;
		logic               down_command;
		logic               up_command;
		logic signed [15:0] motor_position;
		logic signed [15:0] jack_position;
		logic signed [15:0] jack_open_limit;
		logic [31:0]        time_ticks;
	} in_item_t;

	typedef struct packed {
		logic motor_tag;
		logic drive_up;
		logic drive_down;
		logic rezero_request;
		logic value_completed;
		logic mode_forced_running;
	} out_item_t;

	typedef struct packed {
		logic [14:0]        hysteresis;
		logic signed [15:0] zero_pos;
		logic [15:0]        settle_ticks;
	} cfg_t;

	// One motor's stored state
	typedef struct packed {
		logic signed [15:0] open_lim;
		logic signed [15:0] close_lim;
		logic               settle_armed;
		logic [31:0]        settle_start;
		logic signed [15:0] settle_position;
		logic               up_pin;
		logic               down_pin;
	} motor_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/dmlpc_state_mem.sv
`default_nettype none

module dmlpc_state_mem #(
	parameter int DEPTH = 2,
	parameter int IDX_W = 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    rd_en,
	input  wire logic [IDX_W-1:0]        rd_idx,
	input  wire logic                    wr_en,
	input  wire logic [IDX_W-1:0]        wr_idx,
	input  wire dmlpc_pkg::motor_state_t wr_data,
	output dmlpc_pkg::motor_state_t      rd_data
);
	import dmlpc_pkg::*;

	motor_state_t mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	motor_state_t rd_s1;
	logic         vld_s1;
	logic         byp_s1;
	motor_state_t byp_s1_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_s1       <= mem[rd_idx];
			byp_s1_data <= wr_data;
		end
	end

	// Valid bits stand in for the zero reset of the entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
			byp_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= vld_q[rd_idx];
				byp_s1 <= wr_en && (wr_idx == rd_idx);
			end
		end
	end

	// Forward a write that landed on the same edge as the read.
	always_comb begin
		if (byp_s1) begin
			rd_data = byp_s1_data;
		end else if (vld_s1) begin
			rd_data = rd_s1;
		end else begin
			rd_data = '0;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/dmlpc_update.sv
`default_nettype none

module dmlpc_update (
	input  wire dmlpc_pkg::cfg_t         cfg,
	input  wire dmlpc_pkg::in_item_t     item,
	input  wire logic                    out_of_range,
	input  wire dmlpc_pkg::motor_state_t cur,
	input  wire logic                    flag,
	output dmlpc_pkg::motor_state_t      nxt,
	output logic                         wr_en,
	output logic                         flag_nxt,
	output dmlpc_pkg::out_item_t         res
);
	import dmlpc_pkg::*;

	logic signed [17:0] h18;
	logic signed [17:0] pos18;
	logic signed [17:0] jack18;
	logic signed [17:0] jlim18;
	logic signed [17:0] tgt18;
	logic               window;
	logic               below;
	logic               above;
	logic [31:0]        elapsed;
	logic               rezero;
	logic               forced;

	assign h18     = $signed({3'b000, cfg.hysteresis});
	assign pos18   = 18'(item.motor_position);
	assign jack18  = 18'(item.jack_position);
	assign jlim18  = 18'(item.jack_open_limit);
	assign tgt18   = item.down_command ? 18'(cur.open_lim) : 18'(cur.close_lim);
	assign window  = (jack18 > jlim18 - h18) && (jack18 < jlim18 + h18);
	assign below   = pos18 < tgt18 - h18;
	assign above   = pos18 > tgt18 + h18;
	assign elapsed = item.time_ticks - cur.settle_start;

	always_comb begin
		nxt      = cur;
		flag_nxt = flag;
		rezero   = 1'b0;
		forced   = 1'b0;
		unique case (item.interface_mode)
			MODE_RUNNING: begin
				if (item.setting_stage == STAGE_DONE) begin
					if (item.down_command || (item.up_command && window)) begin
						nxt.up_pin   = below;
						nxt.down_pin = !below && above;
					end else if (!item.up_command) begin
						nxt.up_pin   = 1'b0;
						nxt.down_pin = 1'b0;
					end
				end else if (item.setting_stage == STAGE_JACK_LIM) begin
					if (window) begin
						nxt.up_pin   = item.down_command;
						nxt.down_pin = !item.down_command && item.up_command;
						if (!item.down_command && !item.up_command) begin
							rezero        = 1'b1;
							nxt.close_lim = cfg.zero_pos;
						end
					end
				end else begin
					nxt.up_pin   = 1'b0;
					nxt.down_pin = 1'b0;
				end
			end
			MODE_LENGTH: begin
				if (!cur.settle_armed) begin
					nxt.settle_armed    = 1'b1;
					nxt.settle_start    = item.time_ticks;
					nxt.settle_position = item.motor_position;
				end else if (elapsed > {16'd0, cfg.settle_ticks}) begin
					nxt.settle_armed = 1'b0;
					if (item.motor_position == cur.settle_position) begin
						nxt.open_lim = item.motor_position;
						flag_nxt     = 1'b1;
					end
				end
				if (window) begin
					nxt.up_pin   = item.down_command;
					nxt.down_pin = !item.down_command && item.up_command;
					// A drive command inside the jack window clears the completed flag.
					if (item.down_command || item.up_command) begin
						flag_nxt = 1'b0;
					end
				end
			end
			MODE_JACK_ZERO, MODE_JACK_DOWN, MODE_JACK_UP: begin
				nxt.up_pin   = 1'b0;
				nxt.down_pin = 1'b0;
			end
			default: begin
				forced = 1'b1;
			end
		endcase
		if (out_of_range) begin
			flag_nxt = flag;
		end
	end

	assign wr_en = !out_of_range && !forced;

	always_comb begin
		res.motor_tag           = item.motor_id;
		res.drive_up            = !out_of_range && nxt.up_pin;
		res.drive_down          = !out_of_range && nxt.down_pin;
		res.rezero_request      = !out_of_range && rezero;
		res.value_completed     = flag_nxt;
		res.mode_forced_running = !out_of_range && forced;
	end

endmodule

`default_nettype wire

// File: hw/rtl/dual_motor_limit_position_controller.sv
`default_nettype none

// Position limit controller for up to MOTOR_COUNT motors sharing one update
// channel. Each transfer on the input carries one update for one motor and
// yields exactly one result transfer, in order. One update is accepted every
// clock cycle unless the input stalls; the accepting edge performs the
// registered read of the motor's state memory; the update, write-back and
// output register load follow once stage 1 is allowed to advance.
// Updates to the same motor on consecutive cycles are handled by forwarding
// the write-back into the read, so no bubble is ever inserted. The input
// stalls only while the output register holds a result that the receiver is
// stalling. Configuration writes (hysteresis, zero point, settle ticks) take
// effect at once and must be issued only while no update is in flight. All
// limits, settle state and pin levels reset to zero, the completed flag
// clears and settle ticks resets to 20; no clearing pass is needed after
// reset.
module dual_motor_limit_position_controller #(
	parameter int MOTOR_COUNT = 2
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write,
	input  wire logic [dmlpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dmlpc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire dmlpc_pkg::in_item_t           in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output dmlpc_pkg::out_item_t               out_data
);
	import dmlpc_pkg::*;

	localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

	cfg_t         cfg_q;
	logic         v_s1;
	in_item_t     item_s1;
	logic         flag_q;
	logic         adv;
	logic         acc;
	logic         oor_s1;
	motor_state_t cur;
	motor_state_t nxt;
	logic         upd_we;
	logic         mem_we;
	logic         flag_nxt;
	out_item_t    res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hysteresis   <= '0;
			cfg_q.zero_pos     <= '0;
			cfg_q.settle_ticks <= SETTLE_TICKS_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_HYSTERESIS:   cfg_q.hysteresis   <= cfg_data[14:0];
				CFG_ZERO_POS:     cfg_q.zero_pos     <= $signed(cfg_data);
				CFG_SETTLE_TICKS: cfg_q.settle_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance stage 1 whenever the output register is empty or being taken.
	assign adv      = !out_valid || !out_stall;
	assign in_stall = v_s1 && !adv;
	assign acc      = in_valid && !in_stall;
	assign oor_s1   = 32'(item_s1.motor_id) >= MOTOR_COUNT;
	assign mem_we   = v_s1 && adv && upd_we;

	dmlpc_state_mem #(
		.DEPTH (MOTOR_COUNT),
		.IDX_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc),
		.rd_idx  (IDX_W'(in_data.motor_id)),
		.wr_en   (mem_we),
		.wr_idx  (IDX_W'(item_s1.motor_id)),
		.wr_data (nxt),
		.rd_data (cur)
	);

	dmlpc_update u_upd (
		.cfg          (cfg_q),
		.item         (item_s1),
		.out_of_range (oor_s1),
		.cur          (cur),
		.flag         (flag_q),
		.nxt          (nxt),
		.wr_en        (upd_we),
		.flag_nxt     (flag_nxt),
		.res          (res)
	);

	// Hold the update payload alongside the memory read.
	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1 <= in_data;
		end
		if (adv && v_s1) begin
			out_data <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
			flag_q    <= 1'b0;
		end else begin
			if (!in_stall) begin
				v_s1 <= in_valid;
			end
			if (adv) begin
				out_valid <= v_s1;
			end
			// Shared completed flag changes only as an update retires.
			if (adv && v_s1) begin
				flag_q <= flag_nxt;
			end
		end
	end

`ifndef SYNTHESIS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1)
		else $error("input stalled with stage 1 empty");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> v_s1)
		else $error("accepted update did not reach stage 1");

	a_write_on_retire: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (v_s1 && adv))
		else $error("state write without a retiring update");

	a_result_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_s1))
		else $error("result appeared without an update in stage 1");

	a_flag_stable_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(v_s1) |-> $stable(flag_q))
		else $error("completed flag changed with no update retiring");
`endif

endmodule

`default_nettype wire

// File: dv/dual_motor_limit_position_controller_tb.sv
module dual_motor_limit_position_controller_tb;
	import dmlpc_pkg::*;

	localparam int MOTORS = 2;
	localparam int PHASES = 9;
	localparam int UPDATES_PER_PHASE = 100;
	// Drain margin for results still passing through the block, with slack on top.
	localparam int DRAIN_CYCLES = 8;
	// Longest sender gap plus longest receiver stall is well under this.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT = 150;

	// Codes the package leaves unnamed.
	localparam logic [2:0] MODE_SPARE_A = 3'd5;
	localparam logic [2:0] MODE_SPARE_B = 3'd6;
	localparam logic [2:0] MODE_SPARE_C = 3'd7;
	localparam logic [1:0] STAGE_OTHER = 2'd2;
	localparam logic [1:0] STAGE_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef enum logic [1:0] {
		DRIVE_OFF,
		DRIVE_OPEN,
		DRIVE_CLOSE
	} drive_dir_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;

	dual_motor_limit_position_controller #(
		.MOTOR_COUNT(MOTORS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	// Shadow copy of the configuration registers.
	logic [14:0] hyst_m;
	logic signed [15:0] zero_m;
	logic [15:0] settle_m;

	// Shadow copy of the per-motor limit state and the shared completed flag.
	int open_lim [MOTORS];
	int close_lim [MOTORS];
	bit armed [MOTORS];
	logic [31:0] start_tick [MOTORS];
	int still_pos [MOTORS];
	bit pin_up [MOTORS];
	bit pin_dn [MOTORS];
	bit done_flag;

	// Updates waiting to be driven, and results expected back in order.
	in_item_t pending_updates [$];
	out_item_t expected_results [$];

	// Stimulus-side bookkeeping: tick clock per motor and the limits the
	// queued sequences are expected to leave behind.
	logic [31:0] gen_tick [MOTORS];
	int gen_open [MOTORS];
	int gen_close [MOTORS];

	int mismatches = 0;
	int in_gap = 0;
	int stall_left = 0;
	int quiet_cycles = 0;
	bit no_idle = 1'b0;

	initial begin
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void set_pins(int m, drive_dir_t dir);
		pin_up[m] = (dir == DRIVE_OPEN);
		pin_dn[m] = (dir == DRIVE_CLOSE);
	endfunction

	// Drive toward target with a dead band of +/- h; compares at 32 bits.
	function automatic void seek_limit(int m, int pos, int target, int h);
		if (pos < target - h)
			set_pins(m, DRIVE_OPEN);
		else if (pos > target + h)
			set_pins(m, DRIVE_CLOSE);
		else
			set_pins(m, DRIVE_OFF);
	endfunction

	function automatic out_item_t predict_update(in_item_t u);
		out_item_t r;
		int m;
		int h;
		int pos;
		int jack;
		int jlim;
		bit win;
		bit rez;
		bit forced;
		logic [31:0] elapsed;
		m = u.motor_id;
		h = hyst_m;
		pos = $signed(u.motor_position);
		jack = $signed(u.jack_position);
		jlim = $signed(u.jack_open_limit);
		rez = 1'b0;
		forced = 1'b0;
		win = (jack > jlim - h) && (jack < jlim + h);
		case (u.interface_mode)
			MODE_RUNNING: begin
				if (u.setting_stage == STAGE_DONE) begin
					if (u.down_command) begin
						seek_limit(m, pos, open_lim[m], h);
					end else if (u.up_command) begin
						// Up acts only inside the jack window; else hold the pins.
						if (win)
							seek_limit(m, pos, close_lim[m], h);
					end else begin
						set_pins(m, DRIVE_OFF);
					end
				end else if (u.setting_stage == STAGE_JACK_LIM) begin
					if (win) begin
						if (u.down_command) begin
							set_pins(m, DRIVE_OPEN);
						end else if (u.up_command) begin
							set_pins(m, DRIVE_CLOSE);
						end else begin
							set_pins(m, DRIVE_OFF);
							rez = 1'b1;
							close_lim[m] = zero_m;
						end
					end
				end else begin
					set_pins(m, DRIVE_OFF);
				end
			end
			MODE_LENGTH: begin
				if (!armed[m]) begin
					armed[m] = 1'b1;
					start_tick[m] = u.time_ticks;
					still_pos[m] = pos;
				end else begin
					// Elapsed time wraps modulo 2^32.
					elapsed = u.time_ticks - start_tick[m];
					if (elapsed > {16'd0, settle_m}) begin
						armed[m] = 1'b0;
						if (pos == still_pos[m]) begin
							open_lim[m] = pos;
							done_flag = 1'b1;
						end
					end
				end
				// A drive command after a capture clears the flag again.
				if (win) begin
					if (u.down_command) begin
						set_pins(m, DRIVE_OPEN);
						done_flag = 1'b0;
					end else if (u.up_command) begin
						set_pins(m, DRIVE_CLOSE);
						done_flag = 1'b0;
					end else begin
						set_pins(m, DRIVE_OFF);
					end
				end
			end
			MODE_JACK_ZERO, MODE_JACK_DOWN, MODE_JACK_UP: begin
				set_pins(m, DRIVE_OFF);
			end
			default: begin
				forced = 1'b1;
			end
		endcase
		r.motor_tag = u.motor_id;
		r.drive_up = pin_up[m];
		r.drive_down = pin_dn[m];
		r.rezero_request = rez;
		r.value_completed = done_flag;
		r.mode_forced_running = forced;
		return r;
	endfunction

	function automatic void reset_model();
		hyst_m = '0;
		zero_m = '0;
		settle_m = SETTLE_TICKS_RESET;
		done_flag = 1'b0;
		for (int i = 0; i < MOTORS; i++) begin
			open_lim[i] = 0;
			close_lim[i] = 0;
			armed[i] = 1'b0;
			start_tick[i] = '0;
			still_pos[i] = 0;
			pin_up[i] = 1'b0;
			pin_dn[i] = 1'b0;
			gen_tick[i] = '0;
			gen_open[i] = 0;
			gen_close[i] = 0;
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic int clamp16(int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic int rand16();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	function automatic int pick_position();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return int'($urandom_range(0, 4000)) - 2000;
		if (r < 78)
			return -32768;
		if (r < 85)
			return 32767;
		return rand16();
	endfunction

	function automatic int pick_jack_limit();
		if ($urandom_range(0, 4) != 0)
			return int'($urandom_range(0, 2000)) - 1000;
		return rand16();
	endfunction

	// Jack reading inside the open window around jlim, or just past its edge.
	function automatic int pick_jack(int jlim, bit in_window);
		int h;
		h = hyst_m;
		if (in_window) begin
			if (h == 0)
				return jlim;
			return clamp16(jlim + int'($urandom_range(0, 2 * h - 2)) - (h - 1));
		end
		if ($urandom_range(0, 1))
			return clamp16(jlim + h + int'($urandom_range(0, 40)));
		return clamp16(jlim - h - int'($urandom_range(0, 40)));
	endfunction

	// Most gaps are short, a few are long; none in a quiet phase.
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	task automatic push_update(bit m, logic [2:0] mode, logic [1:0] stage, bit dn, bit up,
			int pos, int jack, int jlim, logic [31:0] ticks);
		in_item_t u;
		u.motor_id = m;
		u.interface_mode = mode;
		u.setting_stage = stage;
		u.down_command = dn;
		u.up_command = up;
		u.motor_position = pos[15:0];
		u.jack_position = jack[15:0];
		u.jack_open_limit = jlim[15:0];
		u.time_ticks = ticks;
		pending_updates.push_back(u);
	endtask

	// Length-set run: hold the position still long enough to learn it.
	task automatic queue_learn(bit m);
		int base;
		int n;
		int pos;
		int jlim;
		int step;
		int r;
		base = pick_position();
		jlim = pick_jack_limit();
		n = $urandom_range(2, 5);
		// Now and then start right below the tick wrap.
		if ($urandom_range(0, 9) == 0)
			gen_tick[m] = 32'hFFFF_FFFF - $urandom_range(0, settle_m);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 7)
				step = int'(settle_m) + 1 + int'($urandom_range(0, 2));
			else
				step = $urandom_range(0, settle_m);
			gen_tick[m] = gen_tick[m] + step;
			pos = ($urandom_range(0, 99) < 85) ? base
				: clamp16(base + int'($urandom_range(0, 4)) - 2);
			r = $urandom_range(0, 9);
			push_update(m, MODE_LENGTH, 2'($urandom_range(0, 3)), r == 8, r == 9, pos,
				pick_jack(jlim, $urandom_range(0, 99) < 85), jlim, gen_tick[m]);
		end
		gen_open[m] = base;
	endtask

	// Normal running: drive toward the learned limits around the dead band.
	task automatic queue_seek(bit m);
		int n;
		int h;
		int target;
		int pos;
		int jlim;
		int r;
		bit dn;
		bit up;
		h = hyst_m;
		jlim = pick_jack_limit();
		n = $urandom_range(2, 6);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			dn = (r < 45);
			up = (r >= 45) && (r < 90);
			if (r >= 95) begin
				dn = 1'b1;
				up = 1'b1;
			end
			target = up && !dn ? gen_close[m] : gen_open[m];
			if ($urandom_range(0, 9) < 8)
				pos = clamp16(target + int'($urandom_range(0, 2 * h + 6)) - (h + 3));
			else
				pos = pick_position();
			gen_tick[m] = gen_tick[m] + $urandom_range(1, 5);
			push_update(m, MODE_RUNNING, STAGE_DONE, dn, up, pos,
				pick_jack(jlim, $urandom_range(0, 99) < 85), jlim, gen_tick[m]);
		end
	endtask

	// Jack-up-limit stage: jog inside the window, or re-zero with no command.
	task automatic queue_jog(bit m);
		int n;
		int jlim;
		int r;
		bit in_window;
		jlim = pick_jack_limit();
		n = $urandom_range(1, 4);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 2);
			in_window = $urandom_range(0, 99) < 80;
			gen_tick[m] = gen_tick[m] + $urandom_range(1, 5);
			push_update(m, MODE_RUNNING, STAGE_JACK_LIM, r == 1, r == 2, pick_position(),
				pick_jack(jlim, in_window), jlim, gen_tick[m]);
			if (in_window && r == 0)
				gen_close[m] = zero_m;
		end
	endtask

	task automatic queue_noise();
		push_update(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
			2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			rand16(), rand16(), rand16(), $urandom());
	endtask

	task automatic queue_random(int count);
		int start;
		int r;
		bit m;
		start = pending_updates.size();
		while (pending_updates.size() - start < count) begin
			m = 1'($urandom_range(0, 1));
			r = $urandom_range(0, 99);
			if (r < 35)
				queue_learn(m);
			else if (r < 65)
				queue_seek(m);
			else if (r < 80)
				queue_jog(m);
			else
				queue_noise();
		end
	endtask

	// Hand-picked updates for the corners. Assumes hysteresis 200,
	// zero point -300 and settle ticks 3, with jack limit 0.
	task automatic queue_directed();
		// Learn the open limit of motor 0 at 1000.
		push_update(0, MODE_LENGTH, STAGE_DONE, 0, 0, 1000, 0, 0, 100);
		push_update(0, MODE_LENGTH, STAGE_DONE, 0, 0, 1000, 0, 0, 104);
		// Below, above and inside the band around the open limit.
		push_update(0, MODE_RUNNING, STAGE_DONE, 1, 0, -32768, 0, 0, 105);
		// Up outside the jack window: hold the open drive.
		push_update(0, MODE_RUNNING, STAGE_DONE, 0, 1, 100, 500, 0, 106);
		push_update(0, MODE_RUNNING, STAGE_DONE, 1, 0, 32767, 0, 0, 107);
		push_update(0, MODE_RUNNING, STAGE_DONE, 1, 0, 1000, 0, 0, 108);
		// Re-zero motor 1, then seek its new close limit.
		push_update(1, MODE_RUNNING, STAGE_JACK_LIM, 0, 0, 5, 0, 0, 0);
		push_update(1, MODE_RUNNING, STAGE_DONE, 0, 1, 32767, -199, 0, 1);
		push_update(1, MODE_RUNNING, STAGE_JACK_LIM, 1, 0, 0, 199, 0, 2);
		push_update(1, MODE_RUNNING, STAGE_JACK_LIM, 0, 1, 0, 0, 0, 3);
		// Jack on the window edge is outside: hold.
		push_update(1, MODE_RUNNING, STAGE_JACK_LIM, 0, 0, 0, 200, 0, 4);
		push_update(1, MODE_RUNNING, STAGE_OTHER, 1, 0, 0, 0, 0, 5);
		push_update(1, MODE_RUNNING, STAGE_SPARE, 0, 1, 0, 0, 0, 6);
		// Jack modes switch the drive off.
		push_update(0, MODE_RUNNING, STAGE_DONE, 1, 0, -32768, 0, 0, 109);
		push_update(0, MODE_JACK_ZERO, STAGE_DONE, 1, 1, 0, 0, 0, 110);
		push_update(0, MODE_RUNNING, STAGE_DONE, 1, 0, 32767, 0, 0, 111);
		push_update(0, MODE_JACK_DOWN, STAGE_DONE, 1, 0, 0, 0, 0, 112);
		push_update(0, MODE_JACK_UP, STAGE_DONE, 0, 1, 0, 0, 0, 113);
		// Invalid modes hold everything and flag a forced return.
		push_update(0, MODE_RUNNING, STAGE_DONE, 1, 0, -32768, 0, 0, 114);
		push_update(0, MODE_SPARE_A, STAGE_DONE, 0, 0, 0, 0, 0, 115);
		push_update(1, MODE_SPARE_B, STAGE_JACK_LIM, 1, 1, 32767, 32767, -32768, 116);
		push_update(0, MODE_SPARE_C, STAGE_SPARE, 0, 1, -32768, -32768, 32767, 117);
		// Learn across the tick wrap, jack far outside its window.
		push_update(1, MODE_LENGTH, STAGE_DONE, 0, 0, -5, -32768, 32767, 32'hFFFF_FFFF);
		push_update(1, MODE_LENGTH, STAGE_DONE, 0, 0, -5, 32767, -32768, 32'h0000_0003);
		// Capture and a down command in the same update.
		push_update(1, MODE_LENGTH, STAGE_DONE, 0, 0, 32767, 0, 0, 10);
		push_update(1, MODE_LENGTH, STAGE_DONE, 1, 0, 32767, 0, 0, 20);
		// Elapsed equal to settle ticks does not capture; a moved position drops it.
		push_update(0, MODE_LENGTH, STAGE_DONE, 0, 0, 9, 0, 0, 50);
		push_update(0, MODE_LENGTH, STAGE_DONE, 0, 0, 9, 0, 0, 53);
		push_update(0, MODE_LENGTH, STAGE_DONE, 0, 0, 10, 0, 0, 54);
		gen_open[0] = 1000;
		gen_open[1] = 32767;
		gen_close[1] = -300;
	endtask

	// ------------------------------------------------------------------
	// Configuration
	// ------------------------------------------------------------------

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_HYSTERESIS: hyst_m = val[14:0];
			CFG_ZERO_POS: zero_m = $signed(val);
			CFG_SETTLE_TICKS: settle_m = val;
			default: ;
		endcase
	endtask

	task automatic program_phase(int p);
		int h;
		int zp;
		int st;
		logic [CFG_DATA_W-1:0] d;
		case (p)
			0: begin
				h = 200;
				zp = -300;
				st = 3;
			end
			1: begin
				h = 0;
				zp = 0;
				st = 20;
			end
			2: begin
				h = 32767;
				zp = 32767;
				st = 0;
			end
			3: begin
				h = 1;
				zp = -32768;
				st = 65535;
			end
			4: begin
				h = 50;
				zp = 0;
				st = 1;
			end
			default: begin
				h = $urandom_range(0, 3000);
				zp = rand16();
				st = $urandom_range(0, 40);
			end
		endcase
		// The top bit is unused by hysteresis; toggle it anyway.
		d = h[15:0];
		d[15] = 1'($urandom_range(0, 1));
		write_reg(CFG_HYSTERESIS, d);
		write_reg(CFG_ZERO_POS, zp[15:0]);
		write_reg(CFG_SETTLE_TICKS, st[15:0]);
		if (p == 3)
			write_reg(CFG_SPARE, 16'(rand16()));
	endtask

	// Hold until every queued update has gone in and its result come back.
	task automatic wait_idle();
		while (pending_updates.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Driver: feed updates from the pending queue with random gaps.
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap = 0;
		end else begin
			// Predict at the transfer, in acceptance order.
			if (in_valid && !in_stall)
				expected_results.push_back(predict_update(in_data));
			// Hold a stalled payload; otherwise advance or idle.
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_updates.size() > 0) begin
					in_data <= pending_updates.pop_front();
					in_valid <= 1'b1;
					in_gap = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: stall at random and check each result transfer.
	// ------------------------------------------------------------------

	function automatic void check_field(string fname, logic want, logic got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: %s mismatch, expected %0b actual %0b", $time, fname, want, got);
		end
	endfunction

	task automatic check_result(out_item_t got);
		out_item_t want;
		if (expected_results.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: unexpected result, expected none actual %h", $time, got);
		end else begin
			want = expected_results.pop_front();
			check_field("motor_tag", want.motor_tag, got.motor_tag);
			check_field("drive_up", want.drive_up, got.drive_up);
			check_field("drive_down", want.drive_down, got.drive_down);
			check_field("rezero_request", want.rezero_request, got.rezero_request);
			check_field("value_completed", want.value_completed, got.value_completed);
			check_field("mode_forced_running", want.mode_forced_running,
				got.mode_forced_running);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall)
				check_result(out_data);
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_left = pick_gap();
			end
		end
	end

	// Watchdog: drop the run after too long without any transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("dual_motor_limit_position_controller regression: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence: reset, then phases of configuration plus traffic.
	// ------------------------------------------------------------------

	initial begin
		reset_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < PHASES; p++) begin
			// Reconfigure only while nothing is in flight.
			program_phase(p);
			no_idle = (p > 0) && ($urandom_range(0, 3) == 0);
			if (p == 0)
				queue_directed();
			queue_random(UPDATES_PER_PHASE);
			wait_idle();
		end
		if (mismatches == 0 && expected_results.size() == 0)
			$display("dual_motor_limit_position_controller regression: pass");
		else
			$display("dual_motor_limit_position_controller regression: fail");
		$finish;
	end

endmodule
